### sv/bmp24sp_pkg.sv
package bmp24sp_pkg;

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 96;

    // Header byte offsets
    localparam logic [5:0] HDR_WIDTH_OFS  = 6'd18;
    localparam logic [5:0] HDR_HEIGHT_OFS = 6'd22;
    localparam logic [5:0] HDR_BPP_OFS    = 6'd28;
    localparam logic [5:0] HDR_LAST       = 6'd53;

    localparam logic [15:0] BPP_RGB24 = 16'd24;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    // Bit positions of fields in master tdata
    localparam int MD_ROW_LSB = 24;
    localparam int MD_ERR_BIT = 90;

    typedef struct packed {
        logic        kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] row;
        logic [11:0] column;
        logic        last_pixel;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [15:0] bits_per_pixel;
        logic        format_error;
    } t_result;

endpackage

### sv/bmp24_stream_parser.sv
// Streaming 24-bit BMP parser. Feed the file one byte per request on the slave
// side, with tuser high on the first header byte; that byte restarts the parser
// at any time. After the 54th header byte one header result (tuser 0) gives the
// width, height and bits per pixel; the pixel data offset field is ignored and
// pixels are taken to follow the header directly. Each blue-green-red triple
// then yields one pixel result (tuser 1) with its stored row and column; row
// padding is dropped and tlast marks the final pixel, or the header result of
// an empty or malformed image (bpp other than 24, width above MAX_WIDTH or
// height above MAX_HEIGHT), after which bytes are ignored until the next start.
// The block takes one byte every cycle while its skid entry is empty; each
// result is registered before it shows on the master side. A two-entry output
// stage keeps the slave side open for one more result while the master stalls.
module bmp24_stream_parser
    import bmp24sp_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // [7:0] data_byte
    input  logic                i_s_tuser,  // [0] start_of_file
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,  // red, green, blue, row, column, image_width,
                                            // image_height, bits_per_pixel, format_error
    output logic                o_m_tuser,  // [0] kind
    output logic                o_m_tlast   // last_pixel
);

    // Width of the byte count of a row, padding included
    localparam int RB_W = $clog2(MAX_WIDTH * 3 + 4);
    localparam logic [31:0] MAX_W32 = 32'(MAX_WIDTH);
    localparam logic [31:0] MAX_H32 = 32'(MAX_HEIGHT);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PIXELS,
        PH_DONE
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [5:0]      r_hdr_idx, n_hdr_idx;
    logic [31:0]     r_width, n_width;
    logic [31:0]     r_height, n_height;
    logic [15:0]     r_bpp, n_bpp;
    logic [RB_W-1:0] r_data_len, n_data_len;
    logic [RB_W-1:0] r_row_len, n_row_len;
    logic [RB_W-1:0] r_row_byte, n_row_byte;
    logic [1:0]      r_pix_phase, n_pix_phase;
    logic [7:0]      r_blue, n_blue;
    logic [7:0]      r_green, n_green;
    logic [11:0]     r_col, n_col;
    logic [11:0]     r_row, n_row;

    logic            r_out_valid, r_skid_valid;
    t_result         r_out, r_skid;

    logic            accept;
    logic            res_valid;
    t_result         res;

    assign o_s_tready = !r_skid_valid;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        logic [1:0]      lane_ofs;
        logic [RB_W-1:0] w_low;
        logic            err;
        logic            empty;
        logic            last;
        logic [RB_W-1:0] rb_inc;

        n_phase     = r_phase;
        n_hdr_idx   = r_hdr_idx;
        n_width     = r_width;
        n_height    = r_height;
        n_bpp       = r_bpp;
        n_data_len  = r_data_len;
        n_row_len   = r_row_len;
        n_row_byte  = r_row_byte;
        n_pix_phase = r_pix_phase;
        n_blue      = r_blue;
        n_green     = r_green;
        n_col       = r_col;
        n_row       = r_row;
        res_valid   = 1'b0;
        lane_ofs    = 2'd0;
        w_low       = '0;
        err         = 1'b0;
        empty       = 1'b0;
        last        = 1'b0;
        rb_inc      = '0;

        // Restart clears the captured header
        if (i_s_tuser) begin
            n_phase   = PH_HEADER;
            n_hdr_idx = 6'd0;
            n_width   = 32'd0;
            n_height  = 32'd0;
            n_bpp     = 16'd0;
        end

        if (n_phase == PH_HEADER) begin
            if (n_hdr_idx >= HDR_WIDTH_OFS && n_hdr_idx < HDR_HEIGHT_OFS) begin
                lane_ofs = 2'(n_hdr_idx - HDR_WIDTH_OFS);
                n_width[{lane_ofs, 3'b000} +: 8] = i_s_tdata;
            end else if (n_hdr_idx >= HDR_HEIGHT_OFS && n_hdr_idx < HDR_HEIGHT_OFS + 6'd4) begin
                lane_ofs = 2'(n_hdr_idx - HDR_HEIGHT_OFS);
                n_height[{lane_ofs, 3'b000} +: 8] = i_s_tdata;
            end else if (n_hdr_idx == HDR_BPP_OFS) begin
                n_bpp[7:0] = i_s_tdata;
            end else if (n_hdr_idx == HDR_BPP_OFS + 6'd1) begin
                n_bpp[15:8] = i_s_tdata;
            end

            if (n_hdr_idx < HDR_LAST) begin
                n_hdr_idx = n_hdr_idx + 6'd1;
            end else begin
                err   = n_bpp != BPP_RGB24 || n_width > MAX_W32 || n_height > MAX_H32;
                empty = n_width == 32'd0 || n_height == 32'd0;
                // 3*w padded to 4 bytes: padding equals w mod 4
                w_low       = n_width[RB_W-1:0];
                n_data_len  = {w_low[RB_W-2:0], 1'b0} + w_low;
                n_row_len   = n_data_len + RB_W'(n_width[1:0]);
                n_row_byte  = '0;
                n_pix_phase = 2'd0;
                n_col       = 12'd0;
                n_row       = 12'd0;
                n_phase     = (err || empty) ? PH_DONE : PH_PIXELS;
                res_valid   = 1'b1;
            end
        end else if (n_phase == PH_PIXELS) begin
            if (r_row_byte < r_data_len) begin
                case (r_pix_phase)
                    2'd0: begin
                        n_blue      = i_s_tdata;
                        n_pix_phase = 2'd1;
                    end
                    2'd1: begin
                        n_green     = i_s_tdata;
                        n_pix_phase = 2'd2;
                    end
                    default: begin
                        last = (32'(r_row) + 32'd1 == r_height) &&
                               (32'(r_col) + 32'd1 == r_width);
                        res_valid   = 1'b1;
                        n_pix_phase = 2'd0;
                        n_col       = r_col + 12'd1;
                    end
                endcase
            end
            if (last) begin
                n_phase = PH_DONE;
            end else begin
                rb_inc = r_row_byte + RB_W'(1);
                if (rb_inc >= r_row_len) begin
                    // drop padding, advance to next stored row
                    n_row_byte  = '0;
                    n_pix_phase = 2'd0;
                    n_col       = 12'd0;
                    n_row       = r_row + 12'd1;
                end else begin
                    n_row_byte = rb_inc;
                end
            end
        end

        res.kind           = (n_phase == PH_DONE || n_phase == PH_PIXELS) && r_phase == PH_PIXELS
                             && !i_s_tuser ? KIND_PIXEL : KIND_HEADER;
        res.red            = (res.kind == KIND_PIXEL) ? i_s_tdata : 8'd0;
        res.green          = (res.kind == KIND_PIXEL) ? r_green : 8'd0;
        res.blue           = (res.kind == KIND_PIXEL) ? r_blue : 8'd0;
        res.row            = (res.kind == KIND_PIXEL) ? r_row : 12'd0;
        res.column         = (res.kind == KIND_PIXEL) ? r_col : 12'd0;
        res.last_pixel     = (res.kind == KIND_PIXEL) ? last : (err || empty);
        res.image_width    = (n_width > MAX_W32) ? MAX_W32[12:0] : n_width[12:0];
        res.image_height   = (n_height > MAX_H32) ? MAX_H32[12:0] : n_height[12:0];
        res.bits_per_pixel = n_bpp;
        res.format_error   = (res.kind == KIND_PIXEL) ? 1'b0 : err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_hdr_idx    <= 6'd0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_hdr_idx   <= n_hdr_idx;
                r_width     <= n_width;
                r_height    <= n_height;
                r_bpp       <= n_bpp;
                r_data_len  <= n_data_len;
                r_row_len   <= n_row_len;
                r_row_byte  <= n_row_byte;
                r_pix_phase <= n_pix_phase;
                r_blue      <= n_blue;
                r_green     <= n_green;
                r_col       <= n_col;
                r_row       <= n_row;
            end
            if (r_out_valid && !i_m_tready) begin
                // hold output, park a new result in the skid entry
                if (accept && res_valid) begin
                    r_skid_valid <= 1'b1;
                    r_skid       <= res;
                end
            end else if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept && res_valid;
                r_out       <= res;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last_pixel;
    assign o_m_tdata  = {5'd0, r_out.format_error, r_out.bits_per_pixel, r_out.image_height,
                         r_out.image_width, r_out.column, r_out.row, r_out.blue,
                         r_out.green, r_out.red};

endmodule

### sv/bmp24sp_checker.sv
module bmp24sp_checker
    import bmp24sp_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic                i_s_tuser,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] o_m_tdata,
    input logic                o_m_tuser,
    input logic                o_m_tlast
);

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
                                      $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    a_pix_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_PIXEL |-> !o_m_tdata[MD_ERR_BIT])
        else $error("pixel result carries format error");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_HEADER && o_m_tdata[MD_ERR_BIT] |-> o_m_tlast)
        else $error("format error header without last");

    a_hdr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_HEADER |-> o_m_tdata[MD_ROW_LSB+23:0] == '0)
        else $error("header result with pixel payload");

    // A start byte never yields a result of its own
    a_sof_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser && !(o_m_tvalid && !i_m_tready)
        |=> !o_m_tvalid)
        else $error("result right after a start byte");

endmodule

bind bmp24_stream_parser bmp24sp_checker u_bmp24sp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
